@@ rtl/interval_prime_sum_defines.svh @@
// Assertion macros shared by the interval prime sum RTL.
`ifndef INTERVAL_PRIME_SUM_DEFINES_SVH
`define INTERVAL_PRIME_SUM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ips_pkg.sv @@
// Package with widths, types and helpers for the interval prime sum block.
package ips_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int FIELD_WIDTH = 16;
    localparam int TOTAL_WIDTH = 28;
    localparam int CAND_WIDTH  = VALUE_WIDTH + 1;
    localparam int SQ_WIDTH    = VALUE_WIDTH + 2;
    localparam int CNT_WIDTH   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int WIDE_WIDTH  = (VALUE_WIDTH > FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;

    typedef logic [FIELD_WIDTH-1:0] field_t;
    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [CAND_WIDTH-1:0]  cand_t;
    typedef logic [SQ_WIDTH-1:0]    square_t;
    typedef logic [TOTAL_WIDTH-1:0] total_t;

    // Status returned by the serial remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

    // Keep the low VALUE_WIDTH bits of an input field.
    function automatic value_t fit_value(input field_t f);
        logic [WIDE_WIDTH-1:0] wide;
        wide = WIDE_WIDTH'(f);
        return wide[VALUE_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/ips_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface ips_req_if;
    logic               valid;
    logic               ready;
    ips_pkg::field_t    range_low;
    ips_pkg::field_t    range_high;

    modport source (output valid, output range_low, output range_high, input ready);
    modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface ips_rsp_if;
    logic               valid;
    logic               ready;
    ips_pkg::total_t    prime_sum;

    modport source (output valid, output prime_sum, input ready);
    modport sink   (input valid, input prime_sum, output ready);
endinterface

@@ rtl/interval_prime_sum.sv @@
// Top level of the interval prime sum block: sequencer, accumulator and result register.
// The block takes one request beat carrying the inclusive ends range_low and range_high
// and returns one result beat with the sum of all primes in that interval, saturated at
// 2^28 - 1; an empty interval (low above high) and the values 0 and 1 add nothing.
// Each candidate is tested by trial division with divisors 2, 3, 4 and so on, stopping at
// the first divisor that divides it or once the divisor squared exceeds the candidate.
// Every trial division runs on a bit-serial remainder unit, and the number of divisors tried
// for a candidate is at most about the square root of the candidate. A new request is
// taken only once the previous one has finished; a finished result may wait in the output
// register while the next request is already being worked.
`include "interval_prime_sum_defines.svh"

module interval_prime_sum (
    input  logic          clk,
    input  logic          rst_n,
    ips_req_if.sink       req,
    ips_rsp_if.source     rsp
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CAND = 3'd1;
    localparam logic [2:0] ST_TEST = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam ips_pkg::cand_t   FIRST_PRIME = ips_pkg::CAND_WIDTH'(2);
    localparam ips_pkg::value_t  FIRST_DIV   = ips_pkg::VALUE_WIDTH'(2);
    localparam ips_pkg::square_t FIRST_SQ    = ips_pkg::SQ_WIDTH'(4);
    localparam ips_pkg::total_t  TOTAL_MAX   = '1;

    logic [2:0]             state_reg, state_next;
    ips_pkg::value_t        hi_reg, hi_next;
    ips_pkg::cand_t         cand_reg, cand_next;
    ips_pkg::value_t        div_reg, div_next;
    ips_pkg::square_t       sq_reg, sq_next;
    ips_pkg::total_t        total_reg, total_next;
    logic                   prime_reg, prime_next;
    logic                   out_valid_reg, out_valid_next;
    ips_pkg::total_t        out_sum_reg, out_sum_next;

    logic                   rem_start;
    ips_pkg::rem_status_t   rem_status;
    logic [ips_pkg::TOTAL_WIDTH:0] sum_wide;
    ips_pkg::square_t       cand_sq;
    logic                   past_end;

    // The remainder unit sees only the low VALUE_WIDTH bits; a candidate under test never
    // exceeds the upper end, so the extra carry bit is clear there.
    ips_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (cand_reg[ips_pkg::VALUE_WIDTH-1:0]),
        .divisor  (div_reg),
        .status   (rem_status)
    );

    assign sum_wide = {1'b0, total_reg} + (ips_pkg::TOTAL_WIDTH + 1)'(cand_reg);
    assign cand_sq  = ips_pkg::SQ_WIDTH'(cand_reg);
    assign past_end = (cand_reg > {1'b0, hi_reg});

    always_comb
    begin
        state_next     = state_reg;
        hi_next        = hi_reg;
        cand_next      = cand_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        total_next     = total_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;
        rem_start      = 1'b0;

        // A waiting result leaves once the sink takes it.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cand_next  = ips_pkg::CAND_WIDTH'(ips_pkg::fit_value(req.range_low));
                    hi_next    = ips_pkg::fit_value(req.range_high);
                    total_next = '0;
                    div_next   = '0;
                    state_next = ST_CAND;
                end
            end
            ST_CAND:
            begin
                if (past_end)
                begin
                    state_next = ST_DONE;
                end
                else if (cand_reg < FIRST_PRIME)
                begin
                    // Zero and one are not prime.
                    prime_next = 1'b0;
                    cand_next  = cand_reg + 1'b1;
                end
                else
                begin
                    div_next   = FIRST_DIV;
                    sq_next    = FIRST_SQ;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (sq_reg > cand_sq)
                begin
                    // No divisor up to the square root: the candidate is prime.
                    prime_next = 1'b1;
                    total_next = sum_wide[ips_pkg::TOTAL_WIDTH] ? TOTAL_MAX
                                 : sum_wide[ips_pkg::TOTAL_WIDTH-1:0];
                    cand_next  = cand_reg + 1'b1;
                    state_next = ST_CAND;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (rem_status.done)
                begin
                    if (rem_status.zero)
                    begin
                        prime_next = 1'b0;
                        cand_next  = cand_reg + 1'b1;
                        state_next = ST_CAND;
                    end
                    else
                    begin
                        // (d + 1)^2 = d^2 + 2d + 1 keeps the square without a multiplier.
                        div_next   = div_reg + 1'b1;
                        sq_next    = sq_reg + ips_pkg::SQ_WIDTH'({div_reg, 1'b0})
                                     + ips_pkg::SQ_WIDTH'(1);
                        state_next = ST_TEST;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_sum_next   = total_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cand_reg      <= '0;
            div_reg       <= '0;
            total_reg     <= '0;
            prime_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cand_reg      <= cand_next;
            div_reg       <= div_next;
            total_reg     <= total_next;
            prime_reg     <= prime_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg      <= hi_next;
        sq_reg      <= sq_next;
        out_sum_reg <= out_sum_next;
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.prime_sum = out_sum_reg;

    `IPS_ASSERT_IMPL(a_wait_divisor, clk, rst_n, state_reg == ST_WAIT, div_reg >= FIRST_DIV, "trial divisor below two")
    `IPS_ASSERT_IMPL(a_start_in_range, clk, rst_n, rem_start, sq_reg <= cand_sq && !past_end, "trial division started past the square root")
    `IPS_ASSERT_NEXT(a_end_to_done, clk, rst_n, state_reg == ST_CAND && past_end, state_reg == ST_DONE, "interval end did not close the request")

endmodule

@@ rtl/ips_rem_unit.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`include "interval_prime_sum_defines.svh"

module ips_rem_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  ips_pkg::value_t        dividend,
    input  ips_pkg::value_t        divisor,
    output ips_pkg::rem_status_t   status
);

    localparam logic [ips_pkg::CNT_WIDTH-1:0] LAST_BIT =
        ips_pkg::CNT_WIDTH'(ips_pkg::VALUE_WIDTH - 1);

    ips_pkg::value_t                 shift_reg, shift_next;
    ips_pkg::value_t                 rem_reg, rem_next;
    ips_pkg::value_t                 div_reg, div_next;
    logic [ips_pkg::CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                            run_reg, run_next;
    logic                            done_reg, done_next;
    logic [ips_pkg::VALUE_WIDTH:0]   trial;
    logic [ips_pkg::VALUE_WIDTH:0]   diff;

    // Bring down the next dividend bit and subtract the divisor when it fits.
    assign trial = {rem_reg, shift_reg[ips_pkg::VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = dividend;
            div_next   = divisor;
            rem_next   = '0;
            cnt_next   = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            shift_next = shift_reg << 1;
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[ips_pkg::VALUE_WIDTH-1:0];
            end
            else
            begin
                rem_next = trial[ips_pkg::VALUE_WIDTH-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

    `IPS_ASSERT_IMPL(a_start_when_idle, clk, rst_n, start, !run_reg, "remainder unit restarted while busy")
    `IPS_ASSERT_IMPL(a_done_after_run, clk, rst_n, done_reg, $past(run_reg), "done without a running pass")
    `IPS_ASSERT_NEXT(a_last_bit_done, clk, rst_n, run_reg && !start && cnt_reg == LAST_BIT, done_reg && !run_reg, "last bit did not finish the pass")

endmodule
